// ===== src/cbor_stream_encoder_defines.svh =====
// assertion macros used by the checker file
`ifndef CBOR_STREAM_ENCODER_DEFINES_SVH
`define CBOR_STREAM_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CSE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cbor encoder check failed");

// next-cycle implication, disabled while reset is low
`define CSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cbor encoder check failed");

`endif

// ===== src/cse_pkg.sv =====
package cse_pkg;

    // buffer position counter width
    localparam int POS_W = 16;
    // width used to compare the counter against the capacity register
    localparam int LIM_W = (POS_W > 16) ? POS_W : 16;

    // descriptor queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // command codes
    localparam logic [3:0] CMD_UINT    = 4'd0;
    localparam logic [3:0] CMD_INT     = 4'd1;
    localparam logic [3:0] CMD_BYTES   = 4'd2;
    localparam logic [3:0] CMD_TEXT    = 4'd3;
    localparam logic [3:0] CMD_ARRAY   = 4'd4;
    localparam logic [3:0] CMD_MAP     = 4'd5;
    localparam logic [3:0] CMD_FLOAT   = 4'd6;
    localparam logic [3:0] CMD_BOOL    = 4'd7;
    localparam logic [3:0] CMD_NULL    = 4'd8;
    localparam logic [3:0] CMD_PAYLOAD = 4'd9;
    localparam logic [3:0] CMD_RESTART = 4'd10;

    // head encoding constants
    localparam logic [2:0] MT_MASK       = 3'h7;
    localparam logic [4:0] AI_MAX_INLINE = 5'd23;
    localparam logic [4:0] AI_ONE        = 5'd24;
    localparam logic [4:0] AI_TWO        = 5'd25;
    localparam logic [4:0] AI_FOUR       = 5'd26;
    localparam logic [4:0] AI_EIGHT      = 5'd27;

    localparam logic [7:0] SIMPLE_FLOAT32 = 8'hFA;
    localparam logic [7:0] SIMPLE_TRUE    = 8'hF5;
    localparam logic [7:0] SIMPLE_FALSE   = 8'hF4;
    localparam logic [7:0] SIMPLE_NULL    = 8'hF6;

    // one classified command: head byte plus big-endian argument bytes
    typedef struct packed {
        logic        restart;
        logic [7:0]  head;
        logic [63:0] arg;
        logic [3:0]  nargs;
    } desc_t;

endpackage

// ===== src/cse_front.sv =====
module cse_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    // value [63:0], signed_value [127:64], payload_byte [135:128]
    input  logic [135:0]  s_tdata,
    // cmd [3:0]
    input  logic [3:0]    s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output cse_pkg::desc_t q_desc
);

    logic [3:0]         cmd;
    logic [63:0]        value;
    logic signed [63:0] signed_value;
    logic [7:0]         payload_byte;
    logic [2:0]         major;
    logic [63:0]        arg;
    logic               known;

    assign cmd          = s_tuser;
    assign value        = s_tdata[63:0];
    assign signed_value = s_tdata[127:64];
    assign payload_byte = s_tdata[135:128];

    // word accepted whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && known;

    // major type and argument for head commands
    always_comb begin
        if (cmd == cse_pkg::CMD_INT) begin
            if (signed_value[63]) begin
                major = 3'd1;
                arg   = ~signed_value;
            end else begin
                major = 3'd0;
                arg   = signed_value;
            end
        end else begin
            major = cmd[2:0] & cse_pkg::MT_MASK;
            arg   = value;
        end
    end

    // classify the command into a descriptor
    always_comb begin
        q_desc = '0;
        known  = 1'b1;
        case (cmd)
            cse_pkg::CMD_UINT, cse_pkg::CMD_INT, cse_pkg::CMD_BYTES,
            cse_pkg::CMD_TEXT, cse_pkg::CMD_ARRAY, cse_pkg::CMD_MAP: begin
                q_desc.arg = arg;
                if (arg <= 64'(cse_pkg::AI_MAX_INLINE)) begin
                    q_desc.head  = {major, arg[4:0]};
                    q_desc.nargs = 4'd0;
                end else if (arg <= 64'hFF) begin
                    q_desc.head  = {major, cse_pkg::AI_ONE};
                    q_desc.nargs = 4'd1;
                end else if (arg <= 64'hFFFF) begin
                    q_desc.head  = {major, cse_pkg::AI_TWO};
                    q_desc.nargs = 4'd2;
                end else if (arg <= 64'hFFFF_FFFF) begin
                    q_desc.head  = {major, cse_pkg::AI_FOUR};
                    q_desc.nargs = 4'd4;
                end else begin
                    q_desc.head  = {major, cse_pkg::AI_EIGHT};
                    q_desc.nargs = 4'd8;
                end
            end
            cse_pkg::CMD_FLOAT: begin
                q_desc.head  = cse_pkg::SIMPLE_FLOAT32;
                q_desc.arg   = {32'd0, value[31:0]};
                q_desc.nargs = 4'd4;
            end
            cse_pkg::CMD_BOOL: begin
                q_desc.head = value[0] ? cse_pkg::SIMPLE_TRUE : cse_pkg::SIMPLE_FALSE;
            end
            cse_pkg::CMD_NULL: begin
                q_desc.head = cse_pkg::SIMPLE_NULL;
            end
            cse_pkg::CMD_PAYLOAD: begin
                q_desc.head = payload_byte;
            end
            cse_pkg::CMD_RESTART: begin
                q_desc.restart = 1'b1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/cse_queue.sv =====
module cse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cse_pkg::desc_t push_desc,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output cse_pkg::desc_t head_desc
);

    cse_pkg::desc_t                entry_reg [cse_pkg::Q_DEPTH];
    logic [cse_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [cse_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [cse_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign full      = (count_reg == cse_pkg::Q_CNT_W'(cse_pkg::Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            if (wr_ptr_reg == cse_pkg::Q_PTR_W'(cse_pkg::Q_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == cse_pkg::Q_PTR_W'(cse_pkg::Q_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== src/cse_back.sv =====
module cse_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [15:0]    capacity,
    input  logic           q_empty,
    input  cse_pkg::desc_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    // out_byte [7:0], write_index [23:8], accepted [24], overflow [25], zero [31:26]
    output logic [31:0]    m_tdata,
    output logic           m_tlast
);

    localparam int LIM_W = cse_pkg::LIM_W;

    logic [cse_pkg::POS_W-1:0] count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [3:0]                pos_reg, pos_next;
    logic                      valid_reg, valid_next;
    logic [7:0]                byte_reg, byte_next;
    logic [15:0]               index_reg, index_next;
    logic                      ok_reg, ok_next;
    logic                      ovf_out_reg;
    logic                      last_reg, last_next;

    logic                      slot_free;
    logic                      fire;
    logic [LIM_W-1:0]          cap_ext, pmax_ext, limit, cnt_ext;
    logic [2:0]                lane_sel;
    logic                      room;

    assign slot_free = !valid_reg || m_tready;
    assign fire      = !q_empty && (q_head.restart || slot_free);

    // effective limit is the smaller of capacity and the counter range
    assign cap_ext  = LIM_W'(capacity);
    assign pmax_ext = LIM_W'({cse_pkg::POS_W{1'b1}});
    assign limit    = (cap_ext > pmax_ext) ? pmax_ext : cap_ext;
    assign cnt_ext  = LIM_W'(count_reg);
    assign room     = cnt_ext < limit;

    // argument byte lane, most significant first
    assign lane_sel = 3'(q_head.nargs - pos_reg);

    // byte sequencing and buffer accounting
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        valid_next = valid_reg && !m_tready;
        byte_next  = byte_reg;
        index_next = index_reg;
        ok_next    = ok_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (fire) begin
            if (q_head.restart) begin
                count_next = '0;
                ovf_next   = 1'b0;
                pos_next   = 4'd0;
                q_pop      = 1'b1;
            end else begin
                valid_next = 1'b1;
                if (pos_reg == 4'd0) begin
                    byte_next = q_head.head;
                end else begin
                    byte_next = q_head.arg[{lane_sel, 3'b000} +: 8];
                end
                index_next = 16'd0;
                ok_next    = 1'b0;
                if (!ovf_reg) begin
                    if (room) begin
                        index_next = cnt_ext[15:0];
                        ok_next    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                last_next = (pos_reg == q_head.nargs);
                if (pos_reg == q_head.nargs) begin
                    pos_next = 4'd0;
                    q_pop    = 1'b1;
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        index_reg   <= index_next;
        ok_reg      <= ok_next;
        last_reg    <= last_next;
        if (fire && !q_head.restart) begin
            ovf_out_reg <= ovf_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, ovf_out_reg, ok_reg, index_reg, byte_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== src/cbor_stream_encoder.sv =====
// an accepted command is queued as a descriptor; the back end registers each output byte
// throughput: one byte per cycle unless m_tready stalls; each command's bytes go out in turn
// input stalls only while the two-entry descriptor queue is full
// reset: synchronous, active-low aresetn clears the queue, byte counter,
// overflow flag and output valid; capacity returns to 1024
module cbor_stream_encoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // value [63:0], signed_value [127:64], payload_byte [135:128]
    input  logic [135:0] s_tdata,
    // cmd [3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_byte [7:0], write_index [23:8], accepted [24], overflow [25], zero [31:26]
    output logic [31:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    // capacity [15:0]
    input  logic [15:0]  cfg_data
);

    logic [15:0]    capacity_reg;
    logic           q_full, q_empty, q_push, q_pop;
    cse_pkg::desc_t push_desc, head_desc;

    // capacity register write
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= 16'd1024;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    cse_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc)
    );

    cse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_desc (head_desc)
    );

    cse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (capacity_reg),
        .q_empty  (q_empty),
        .q_head   (head_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== src/cse_checker.sv =====
`include "cbor_stream_encoder_defines.svh"

module cse_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic         m_tlast
);

    // stalled output word holds
    `CSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // a stored byte never carries the overflow flag
    `CSE_ASSERT_IMPL(a_ok_no_ovf, m_tvalid && m_tdata[24], !m_tdata[25])

    // a dropped byte has position zero and overflow set
    `CSE_ASSERT_IMPL(a_drop_fields, m_tvalid && !m_tdata[24], m_tdata[23:8] == 16'd0 && m_tdata[25])

    // padding bits stay zero
    `CSE_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[31:26] == 6'd0)

endmodule

bind cbor_stream_encoder cse_checker u_cse_checker (.*);
